// ===== rtl/rrsg_pkg.sv =====
// Package for the rounded-rectangle span generator: field widths, the queued
// command type, the back-end state type and the corner row-width table.
// No dependencies.
package rrsg_pkg;

  localparam int CoordInW  = 11;
  localparam int CoordOutW = 12;
  localparam int SizeW     = 10;
  localparam int RadiusW   = 4;
  localparam int ColorW    = 16;

  typedef logic [255:0][RadiusW-1:0] dx_tab_t;

  typedef struct packed {
    logic                        plain;
    logic        [RadiusW-1:0]   radius;
    logic signed [CoordOutW-1:0] x_l;
    logic signed [CoordOutW-1:0] x_c;
    logic signed [CoordOutW-1:0] x_rt;
    logic signed [CoordOutW-1:0] y_t;
    logic signed [CoordOutW-1:0] y_c;
    logic signed [CoordOutW-1:0] y_b;
    logic        [SizeW-1:0]     w_full;
    logic        [SizeW-1:0]     h_full;
    logic        [SizeW-1:0]     w_c;
    logic        [SizeW-1:0]     h_c;
    logic        [ColorW-1:0]    color;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAIN,
    ST_BODY,
    ST_CORNER
  } state_t;

  // Entry {r, dy} holds max(1, isqrt(r*r - (r-1-dy)^2)); unused entries are zero.
  function automatic dx_tab_t build_row_dx();
    dx_tab_t t;
    int      d;
    int      sq;
    int      dx;
    t = '0;
    for (int r = 1; r < 16; r++) begin
      for (int dy = 0; dy < r; dy++) begin
        d  = r - 1 - dy;
        sq = r * r - d * d;
        dx = 1;
        while ((dx + 1) * (dx + 1) <= sq) begin
          dx++;
        end
        t[r * 16 + dy] = RadiusW'(dx);
      end
    end
    return t;
  endfunction

  localparam dx_tab_t RowDx = build_row_dx();

endpackage

// ===== rtl/rrsg_ifs.sv =====
// Valid/ready channel interfaces for draw commands and emitted rectangles.
// Depends on rrsg_pkg for field widths.
interface rrsg_in_if;
  import rrsg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [CoordInW-1:0] box_x;
  logic signed [CoordInW-1:0] box_y;
  logic        [SizeW-1:0]    box_w;
  logic        [SizeW-1:0]    box_h;
  logic        [RadiusW-1:0]  radius;
  logic        [ColorW-1:0]   fill_color;

  modport source (output valid, box_x, box_y, box_w, box_h, radius, fill_color,
                  input ready);
  modport sink   (input valid, box_x, box_y, box_w, box_h, radius, fill_color,
                  output ready);
endinterface

interface rrsg_out_if;
  import rrsg_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [CoordOutW-1:0] span_x;
  logic signed [CoordOutW-1:0] span_y;
  logic        [SizeW-1:0]     span_w;
  logic        [SizeW-1:0]     span_h;
  logic        [ColorW-1:0]    span_color;
  logic                        last_span;

  modport source (output valid, span_x, span_y, span_w, span_h, span_color, last_span,
                  input ready);
  modport sink   (input valid, span_x, span_y, span_w, span_h, span_color, last_span,
                  output ready);
endinterface

// ===== rtl/rounded_rect_span_generator_core.sv =====
// Top level of the rounded-rectangle span generator: front end, command queue
// and span sequencer. Depends on rrsg_pkg, rrsg_ifs and the rrsg_* modules.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   box_x box_y box_w box_h radius fill_color
//   out_ch   out  valid/ready   span_x span_y span_w span_h span_color last_span
//
// The back-end sequencer takes a command from the queue in its idle state and
// then emits one rectangle per cycle unless the output stalls: one for a plain
// box, 3 + 4*r for a rounded one, at most 63 per item.
// The two-entry queue lets new items be accepted while a command is expanded.
// Reset clears the queue and the sequencer; nothing else needs clearing.
// An output stall holds the registered rectangle and freezes the expansion.
module rounded_rect_span_generator_core #(
  parameter int MAX_RADIUS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  rrsg_in_if.sink     in_ch,
  rrsg_out_if.source  out_ch
);
  import rrsg_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic full;
  logic pop;
  logic empty;

  rrsg_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .in_ch (in_ch),
    .cmd   (front_cmd),
    .push  (push),
    .full  (full)
  );

  rrsg_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_cmd),
    .full  (full),
    .pop   (pop),
    .dout  (head_cmd),
    .empty (empty)
  );

  rrsg_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head_cmd),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/rrsg_front.sv =====
// Front end: accepts draw commands, clamps the radius, classifies plain versus
// rounded boxes and precomputes edge coordinates. Depends on rrsg_pkg, rrsg_ifs.
module rrsg_front #(
  parameter int MAX_RADIUS = 15
) (
  rrsg_in_if.sink         in_ch,
  output rrsg_pkg::cmd_t  cmd,
  output logic            push,
  input  logic            full
);
  import rrsg_pkg::*;

  localparam logic [RadiusW-1:0] MaxR = RadiusW'(MAX_RADIUS);

  logic        [RadiusW-1:0]   r_cl;
  logic        [SizeW-1:0]     two_r;
  logic signed [CoordOutW-1:0] x_ext;
  logic signed [CoordOutW-1:0] y_ext;
  logic        [CoordOutW-1:0] r_ext;
  logic        [CoordOutW-1:0] w_ext;
  logic        [CoordOutW-1:0] h_ext;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  always_comb begin
    r_cl  = (in_ch.radius > MaxR) ? MaxR : in_ch.radius;
    two_r = {{(SizeW-RadiusW-1){1'b0}}, r_cl, 1'b0};
    x_ext = {in_ch.box_x[CoordInW-1], in_ch.box_x};
    y_ext = {in_ch.box_y[CoordInW-1], in_ch.box_y};
    r_ext = {{(CoordOutW-RadiusW){1'b0}}, r_cl};
    w_ext = {{(CoordOutW-SizeW){1'b0}}, in_ch.box_w};
    h_ext = {{(CoordOutW-SizeW){1'b0}}, in_ch.box_h};

    cmd.plain  = (r_cl == '0) || (in_ch.box_w < two_r) || (in_ch.box_h < two_r);
    cmd.radius = r_cl;
    cmd.x_l    = x_ext;
    cmd.x_c    = x_ext + r_ext;
    cmd.x_rt   = x_ext + w_ext - r_ext;
    cmd.y_t    = y_ext;
    cmd.y_c    = y_ext + r_ext;
    cmd.y_b    = y_ext + h_ext - CoordOutW'(1);
    cmd.w_full = in_ch.box_w;
    cmd.h_full = in_ch.box_h;
    cmd.w_c    = in_ch.box_w - two_r;
    cmd.h_c    = in_ch.box_h - two_r;
    cmd.color  = in_ch.fill_color;
  end

endmodule

// ===== rtl/rrsg_fifo.sv =====
// Short register queue of classified commands between front and back ends.
// Depends on rrsg_pkg for the command type.
module rrsg_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rrsg_pkg::cmd_t  din,
  output logic            full,
  input  logic            pop,
  output rrsg_pkg::cmd_t  dout,
  output logic            empty
);
  import rrsg_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/rrsg_back.sv =====
// Back end: takes one queued command at a time and emits its rectangles, one
// per cycle unless stalled, into an output register. Depends on rrsg_pkg, rrsg_ifs.
module rrsg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rrsg_pkg::cmd_t  head,
  input  logic            empty,
  output logic            pop,
  rrsg_out_if.source      out_ch
);
  import rrsg_pkg::*;

  state_t                      state_r, state_nxt;
  cmd_t                        cmd_r, cmd_nxt;
  logic [1:0]                  idx_r, idx_nxt;
  logic [RadiusW-1:0]          dy_r, dy_nxt;
  logic [1:0]                  q_r, q_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [CoordOutW-1:0] span_x_r, span_x_nxt;
  logic signed [CoordOutW-1:0] span_y_r, span_y_nxt;
  logic [SizeW-1:0]            span_w_r, span_w_nxt;
  logic [SizeW-1:0]            span_h_r, span_h_nxt;
  logic [ColorW-1:0]           span_color_r, span_color_nxt;
  logic                        last_r, last_nxt;

  logic                        load_ok;
  logic                        emit;
  logic                        corner_last;
  logic [RadiusW-1:0]          dx;
  logic [CoordOutW-1:0]        dx_ext;
  logic [CoordOutW-1:0]        dy_ext;
  logic [SizeW-1:0]            r_size;

  assign load_ok     = !out_valid_r || out_ch.ready;
  assign dx          = RowDx[{cmd_r.radius, dy_r}];
  assign dx_ext      = {{(CoordOutW-RadiusW){1'b0}}, dx};
  assign dy_ext      = {{(CoordOutW-RadiusW){1'b0}}, dy_r};
  assign r_size      = {{(SizeW-RadiusW){1'b0}}, cmd_r.radius};
  assign corner_last = (q_r == 2'd3) && (dy_r == cmd_r.radius - 1'b1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          state_nxt = head.plain ? ST_PLAIN : ST_BODY;
        end
      end
      ST_PLAIN: begin
        if (load_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BODY: begin
        if (load_ok && idx_r == 2'd2) begin
          state_nxt = ST_CORNER;
        end
      end
      ST_CORNER: begin
        if (load_ok && corner_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    emit       = 1'b0;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    dy_nxt     = dy_r;
    q_nxt      = q_r;
    span_x_nxt = span_x_r;
    span_y_nxt = span_y_r;
    span_w_nxt = span_w_r;
    span_h_nxt = span_h_r;
    last_nxt   = last_r;
    unique case (state_r)
      ST_IDLE: begin
        pop     = !empty;
        cmd_nxt = head;
        idx_nxt = '0;
        dy_nxt  = '0;
        q_nxt   = '0;
      end
      ST_PLAIN: begin
        emit       = load_ok;
        span_x_nxt = cmd_r.x_l;
        span_y_nxt = cmd_r.y_t;
        span_w_nxt = cmd_r.w_full;
        span_h_nxt = cmd_r.h_full;
        last_nxt   = 1'b1;
      end
      ST_BODY: begin
        emit     = load_ok;
        last_nxt = 1'b0;
        unique case (idx_r)
          2'd0: begin
            span_x_nxt = cmd_r.x_c;
            span_y_nxt = cmd_r.y_t;
            span_w_nxt = cmd_r.w_c;
            span_h_nxt = cmd_r.h_full;
          end
          2'd1: begin
            span_x_nxt = cmd_r.x_l;
            span_y_nxt = cmd_r.y_c;
            span_w_nxt = r_size;
            span_h_nxt = cmd_r.h_c;
          end
          default: begin
            span_x_nxt = cmd_r.x_rt;
            span_y_nxt = cmd_r.y_c;
            span_w_nxt = r_size;
            span_h_nxt = cmd_r.h_c;
          end
        endcase
        if (load_ok) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_CORNER: begin
        emit       = load_ok;
        last_nxt   = corner_last;
        span_x_nxt = q_r[0] ? cmd_r.x_rt : cmd_r.x_c - dx_ext;
        span_y_nxt = q_r[1] ? cmd_r.y_b - dy_ext : cmd_r.y_t + dy_ext;
        span_w_nxt = {{(SizeW-RadiusW){1'b0}}, dx};
        span_h_nxt = SizeW'(1);
        if (load_ok) begin
          q_nxt = q_r + 1'b1;
          if (q_r == 2'd3) begin
            dy_nxt = dy_r + 1'b1;
          end
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
    span_color_nxt = emit ? cmd_r.color : span_color_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    dy_r  <= dy_nxt;
    q_r   <= q_nxt;
    if (emit) begin
      span_x_r     <= span_x_nxt;
      span_y_r     <= span_y_nxt;
      span_w_r     <= span_w_nxt;
      span_h_r     <= span_h_nxt;
      span_color_r <= span_color_nxt;
      last_r       <= last_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.span_x     = span_x_r;
  assign out_ch.span_y     = span_y_r;
  assign out_ch.span_w     = span_w_r;
  assign out_ch.span_h     = span_h_r;
  assign out_ch.span_color = span_color_r;
  assign out_ch.last_span  = last_r;

endmodule
